### src/rh_pkg.sv
// Shared types and constants for the double-modulus rolling hash block.
// Used by every module of the block but rh_ram; depends on nothing.
package rh_pkg;

    localparam int MAX_LEN = 4096;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int HASH_W  = 31;
    localparam int CHAR_W  = 8;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    // Command kinds as classified by the front end.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_REJECT = 2'd3;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_MODA = 2'd1;
    localparam logic [1:0] REG_MODB = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] char_code;
        logic [LEN_W-1:0]  range_start;
        logic [LEN_W-1:0]  range_end;
        logic [LEN_W-1:0]  len_after;
    } cmd_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash_base;
        logic [HASH_W-1:0] modulus_a;
        logic [HASH_W-1:0] modulus_b;
    } cfg_t;

endpackage

### src/double_mod_rolling_hash.sv
// Double-modulus rolling hash: prefix hashes of a byte string and substring queries.
// A clear or rejected item goes to the output register directly; an append or a query
// first takes two passes of the iterative modular reducer for each modulus.
// The back end works on one item at a time and holds it while the output stalls;
// two more wait in the command queue.
// Synchronous active-low reset empties the string and restores the default registers.
module double_mod_rolling_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // char_code[7:0], range_start[20:8], range_end[33:21], pad
    input  logic [1:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // hash_a[30:0], hash_b[61:31], string_length[74:62], pad
    output logic [0:0]  m_tuser,  // error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rh_pkg::*;

    cfg_t cfg_reg;
    logic q_ready, q_push, q_valid, q_pop;
    cmd_t push_cmd, head_cmd;
    logic [1:0] reg_idx;
    logic cfg_we;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hash_base <= HASH_W'(131);
            cfg_reg.modulus_a <= HASH_W'(1000000007);
            cfg_reg.modulus_b <= HASH_W'(998244353);
        end else if (cfg_we) begin
            case (reg_idx)
                REG_BASE: cfg_reg.hash_base <= pwdata[HASH_W-1:0];
                REG_MODA: cfg_reg.modulus_a <= pwdata[HASH_W-1:0];
                REG_MODB: cfg_reg.modulus_b <= pwdata[HASH_W-1:0];
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASE: prdata = {1'b0, cfg_reg.hash_base};
            REG_MODA: prdata = {1'b0, cfg_reg.modulus_a};
            REG_MODB: prdata = {1'b0, cfg_reg.modulus_b};
            default:  prdata = '0;
        endcase
    end

    rh_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_ready(q_ready), .q_push(q_push), .q_cmd(push_cmd)
    );

    rh_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_cmd(push_cmd), .not_full(q_ready),
        .pop(q_pop), .not_empty(q_valid), .head_cmd(head_cmd)
    );

    rh_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_cmd(head_cmd), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );
endmodule

### src/rh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/rh_modmul.sv
// Iterative (x * y + z) mod m: one multiply, then a radix-4 serial reduction.
// Depends on rh_pkg.
module rh_modmul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rh_pkg::HASH_W-1:0] x,
    input  logic [rh_pkg::HASH_W-1:0] y,
    input  logic [rh_pkg::HASH_W-1:0] z,
    input  logic [rh_pkg::HASH_W-1:0] m,
    output logic                      done,
    output logic [rh_pkg::HASH_W-1:0] result
);
    import rh_pkg::*;

    localparam logic [1:0] MM_IDLE = 2'd0;
    localparam logic [1:0] MM_MUL  = 2'd1;
    localparam logic [1:0] MM_ADD  = 2'd2;
    localparam logic [1:0] MM_RUN  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [HASH_W-1:0]   x_reg, y_reg, z_reg, m_reg;
    logic                small_reg;
    logic [2*HASH_W-1:0] prod_reg;
    logic [63:0]         val_reg, val_next;
    logic [HASH_W-1:0]   acc_reg, acc_next;
    logic [HASH_W+1:0]   m3_reg;
    logic [4:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [HASH_W+1:0]   t, m1, m2;

    always_comb begin
        m1 = {2'b00, m_reg};
        m2 = {1'b0, m_reg, 1'b0};
        t  = {acc_reg, val_reg[63:62]};
        state_next = state_reg;
        val_next   = val_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            MM_IDLE: begin
                if (start) begin
                    state_next = MM_MUL;
                end
            end
            MM_MUL: begin
                state_next = MM_ADD;
            end
            MM_ADD: begin
                val_next   = {2'b00, prod_reg} + {33'd0, z_reg};
                acc_next   = '0;
                cnt_next   = 5'd31;
                state_next = MM_RUN;
            end
            MM_RUN: begin
                // acc stays below m, so 4*acc + digit stays below 4m.
                if (t >= m3_reg) begin
                    acc_next = HASH_W'(t - m3_reg);
                end else if (t >= m2) begin
                    acc_next = HASH_W'(t - m2);
                end else if (t >= m1) begin
                    acc_next = HASH_W'(t - m1);
                end else begin
                    acc_next = HASH_W'(t);
                end
                val_next = {val_reg[61:0], 2'b00};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    done_next  = 1'b1;
                    state_next = MM_IDLE;
                end
            end
            default: state_next = MM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        if (state_reg == MM_IDLE && start) begin
            x_reg     <= x;
            y_reg     <= y;
            z_reg     <= z;
            m_reg     <= m;
            small_reg <= (m < HASH_W'(2));
            m3_reg    <= {2'b00, m} + {1'b0, m, 1'b0};
        end
        if (state_reg == MM_MUL) begin
            prod_reg <= x_reg * y_reg;
        end
        val_reg <= val_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign done   = done_reg;
    assign result = small_reg ? '0 : acc_reg;
endmodule

### src/rh_front.sv
// Front end: accepts input transactions, tracks the string length and
// classifies each item into a command for the back end. Depends on rh_pkg.
module rh_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [39:0]               s_tdata,  // char_code, range_start, range_end, zero pad
    input  logic [1:0]                s_tuser,  // action
    input  logic                      q_ready,
    output logic                      q_push,
    output rh_pkg::cmd_t              q_cmd
);
    import rh_pkg::*;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  rs, re;

    assign ch = s_tdata[7:0];
    assign rs = s_tdata[20:8];
    assign re = s_tdata[33:21];
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        len_next          = len_reg;
        q_cmd.char_code   = ch;
        q_cmd.range_start = rs;
        q_cmd.range_end   = re;
        q_cmd.kind        = CMD_REJECT;
        case (s_tuser)
            ACT_CLEAR: begin
                q_cmd.kind = CMD_CLEAR;
                len_next   = '0;
            end
            ACT_APPEND: begin
                if (len_reg != LEN_W'(MAX_LEN)) begin
                    q_cmd.kind = CMD_APPEND;
                    len_next   = len_reg + LEN_W'(1);
                end
            end
            ACT_QUERY: begin
                if (!(rs > re || re > len_reg)) begin
                    q_cmd.kind = CMD_QUERY;
                end
            end
            default: q_cmd.kind = CMD_REJECT;
        endcase
        q_cmd.len_after = len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (q_push) begin
            len_reg <= len_next;
        end
    end
endmodule

### src/rh_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on rh_pkg.
module rh_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  rh_pkg::cmd_t push_cmd,
    output logic         not_full,
    input  logic         pop,
    output logic         not_empty,
    output rh_pkg::cmd_t head_cmd
);
    import rh_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

### src/rh_back.sv
// Back end: reads prefix and power tables, runs the modular units for both
// moduli and drives the result register. Depends on rh_pkg, rh_ram, rh_modmul.
module rh_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  rh_pkg::cfg_t        cfg,
    input  logic                q_valid,
    input  rh_pkg::cmd_t        q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [79:0]         m_tdata,  // hash_a, hash_b, string_length, zero pad
    output logic [0:0]          m_tuser   // error
);
    import rh_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CAP1 = 4'd1;
    localparam logic [3:0] S_CAP2 = 4'd2;
    localparam logic [3:0] S_OP1  = 4'd3;
    localparam logic [3:0] S_W1   = 4'd4;
    localparam logic [3:0] S_OP2  = 4'd5;
    localparam logic [3:0] S_W2   = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0]          state_reg, state_next;
    cmd_t                cmd_reg;
    logic [HASH_W-1:0]   ha1_reg, hb1_reg;   // h[n] or h[l]
    logic [HASH_W-1:0]   pa_reg, pb_reg;     // p[n] or p[r-l]
    logic [HASH_W-1:0]   hra_reg, hrb_reg;   // h[r]
    logic [HASH_W-1:0]   ra_reg, rb_reg;     // first unit results
    logic [HASH_W-1:0]   oa_reg, ob_reg;
    logic                err_reg;
    logic                hz_reg, pz_reg;
    logic                out_valid_reg;
    logic [HASH_W-1:0]   out_a_reg, out_b_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_err_reg;

    logic                h_we;
    logic [LEN_W-1:0]    h_raddr, p_raddr, w_addr;
    logic [2*HASH_W-1:0] h_rdata, p_rdata, h_wdata, p_wdata;
    logic [HASH_W-1:0]   h_a, h_b, p_a, p_b;

    logic                mm_start, done_a, done_b, mm_done;
    logic [HASH_W-1:0]   xa, ya, za, xb, yb, zb, res_a, res_b;
    logic                out_load;

    // Entry zero is never written: it reads as the empty prefix hash and power one.
    assign h_a = hz_reg ? '0 : h_rdata[HASH_W-1:0];
    assign h_b = hz_reg ? '0 : h_rdata[2*HASH_W-1:HASH_W];
    assign p_a = pz_reg ? HASH_W'(1) : p_rdata[HASH_W-1:0];
    assign p_b = pz_reg ? HASH_W'(1) : p_rdata[2*HASH_W-1:HASH_W];

    assign w_addr  = cmd_reg.len_after;
    assign h_wdata = {rb_reg, ra_reg};
    assign p_wdata = {res_b, res_a};

    rh_ram #(.WIDTH(2*HASH_W), .DEPTH(MAX_LEN + 1)) u_prefix_ram (
        .aclk(aclk), .we(h_we), .waddr(w_addr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );
    rh_ram #(.WIDTH(2*HASH_W), .DEPTH(MAX_LEN + 1)) u_power_ram (
        .aclk(aclk), .we(h_we), .waddr(w_addr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    rh_modmul u_mod_a (
        .aclk(aclk), .aresetn(aresetn), .start(mm_start),
        .x(xa), .y(ya), .z(za), .m(cfg.modulus_a), .done(done_a), .result(res_a)
    );
    rh_modmul u_mod_b (
        .aclk(aclk), .aresetn(aresetn), .start(mm_start),
        .x(xb), .y(yb), .z(zb), .m(cfg.modulus_b), .done(done_b), .result(res_b)
    );

    // Both units start together and take the same number of cycles.
    assign mm_done  = done_a && done_b;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        h_raddr    = q_cmd.range_start;
        p_raddr    = q_cmd.range_end - q_cmd.range_start;
        h_we       = 1'b0;
        mm_start   = 1'b0;
        xa = ha1_reg;  ya = cfg.hash_base;  za = {{(HASH_W-CHAR_W){1'b0}}, cmd_reg.char_code};
        xb = hb1_reg;  yb = cfg.hash_base;  zb = {{(HASH_W-CHAR_W){1'b0}}, cmd_reg.char_code};
        case (state_reg)
            S_IDLE: begin
                if (q_cmd.kind == CMD_APPEND) begin
                    h_raddr = q_cmd.len_after - LEN_W'(1);
                    p_raddr = q_cmd.len_after - LEN_W'(1);
                end
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == CMD_APPEND || q_cmd.kind == CMD_QUERY) begin
                        state_next = S_CAP1;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CAP1: begin
                h_raddr    = cmd_reg.range_end;
                state_next = (cmd_reg.kind == CMD_QUERY) ? S_CAP2 : S_OP1;
            end
            S_CAP2: state_next = S_OP1;
            S_OP1: begin
                mm_start = 1'b1;
                if (cmd_reg.kind == CMD_QUERY) begin
                    ya = HASH_W'(1);  za = '0;
                    yb = HASH_W'(1);  zb = '0;
                end
                state_next = S_W1;
            end
            S_W1: begin
                if (mm_done) begin
                    state_next = S_OP2;
                end
            end
            S_OP2: begin
                mm_start = 1'b1;
                if (cmd_reg.kind == CMD_QUERY) begin
                    xa = cfg.modulus_a - ra_reg;  ya = pa_reg;  za = hra_reg;
                    xb = cfg.modulus_b - rb_reg;  yb = pb_reg;  zb = hrb_reg;
                end else begin
                    xa = pa_reg;  za = '0;
                    xb = pb_reg;  zb = '0;
                end
                state_next = S_W2;
            end
            S_W2: begin
                if (mm_done) begin
                    h_we       = (cmd_reg.kind == CMD_APPEND);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (state_reg == S_IDLE && q_valid) begin
            cmd_reg <= q_cmd;
            oa_reg  <= '0;
            ob_reg  <= '0;
            err_reg <= (q_cmd.kind == CMD_REJECT);
            hz_reg  <= (h_raddr == '0);
            pz_reg  <= (p_raddr == '0);
        end
        if (state_reg == S_CAP1) begin
            ha1_reg <= h_a;
            hb1_reg <= h_b;
            pa_reg  <= p_a;
            pb_reg  <= p_b;
            hz_reg  <= (h_raddr == '0);
        end
        if (state_reg == S_CAP2) begin
            hra_reg <= h_a;
            hrb_reg <= h_b;
        end
        if (state_reg == S_W1 && mm_done) begin
            ra_reg <= res_a;
            rb_reg <= res_b;
        end
        if (state_reg == S_W2 && mm_done) begin
            if (cmd_reg.kind == CMD_QUERY) begin
                oa_reg <= res_a;
                ob_reg <= res_b;
            end else begin
                oa_reg <= ra_reg;
                ob_reg <= rb_reg;
            end
        end
        if (out_load) begin
            out_a_reg   <= oa_reg;
            out_b_reg   <= ob_reg;
            out_len_reg <= cmd_reg.len_after;
            out_err_reg <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_len_reg, out_b_reg, out_a_reg};
    assign m_tuser  = out_err_reg;
endmodule

### src/rh_checker.sv
// Port-level checks for the rolling hash block, bound to the top level.
// Depends on rh_pkg and double_mod_rolling_hash.
module rh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import rh_pkg::*;

    // A result that has not been taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transaction");

    // Rejected items carry zero hashes.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[61:0] == 62'd0)
        else $error("error result with nonzero hash");

    // The reported length never exceeds the capacity.
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[74:62] <= LEN_W'(MAX_LEN))
        else $error("string length beyond capacity");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind double_mod_rolling_hash rh_checker u_rh_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
